// ----- src/pvs_pkg.sv -----
// shared types, codes and saturation helper for the production velocity sensitivity block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pvs_pkg;

    // input selector codes carried in s_tuser
    localparam logic [1:0] ACT_LOAD_GRAD = 2'd0;
    localparam logic [1:0] ACT_LOAD_NODE = 2'd1;
    localparam logic [1:0] ACT_COMPUTE   = 2'd2;
    localparam logic [1:0] ACT_IGNORED   = 2'd3;

    // configuration register indexes
    localparam logic REG_DIMENSION  = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_G_RD,
        ST_G_CAP,
        ST_D_MUL,
        ST_D_ACC,
        ST_S_CALC,
        ST_P_MUL,
        ST_P_ACC,
        ST_P_END,
        ST_N_RD,
        ST_N_CAP,
        ST_K_MUL,
        ST_K_ACC,
        ST_O_MUL1,
        ST_O_ACC1,
        ST_O_MUL2,
        ST_O_ACC2,
        ST_O_END,
        ST_EMIT
    } pvs_state_t;

    // terms of the inner sum for one axis
    typedef enum logic [1:0] {
        TERM_GKJ,
        TERM_GJK,
        TERM_SKJ,
        TERM_ND
    } pvs_term_t;

    typedef struct packed {
        logic load;
        logic acc;
        logic clr;
        logic neg;
    } pvs_mac_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/pvs_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/pvs_mac.sv -----
// shared multiply-accumulate: registered product, rounded and added or subtracted
// uses pvs_pkg
`timescale 1ns / 1ps
`default_nettype none

module pvs_mac #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire pvs_pkg::pvs_mac_ctl_t ctl,
    input  wire logic signed [31:0]    op_a,
    input  wire logic signed [31:0]    op_b,
    output logic signed [63:0]         acc
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] rnd;
    logic signed [63:0] base;
    logic signed [63:0] acc_next;

    always_comb begin
        rnd = (prod_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        base = ctl.clr ? 64'sd0 : acc_reg;
        acc_next = ctl.neg ? (base - rnd) : (base + rnd);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            prod_reg <= op_a * op_b;
        end
        if (ctl.acc) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ----- src/production_velocity_sensitivity.sv -----
// Load beats are taken only in ST_IDLE. A compute beat runs a setup phase (gradient rows, trace,
// symmetric part, production), then per node an inner sum for each of nd axes (nd = 2 or 3), plus any
// result stall, all on the single shared multiply-accumulate; one result beat per node, no input until the last.
// Synchronous active-low reset returns control and configuration to defaults; store contents are not cleared.
// top level: gradient and node rams, sequencer, shared mac; uses pvs_pkg, pvs_ram, pvs_mac
`timescale 1ns / 1ps
`default_nettype none

module production_velocity_sensitivity #(
    parameter int MAX_NODES = 8,
    parameter int MAX_DIM   = 3,
    parameter int FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_addr,
    input  wire logic [3:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // index, row_x, row_y, row_z, deriv_x, deriv_y, deriv_z, turb_visc
    input  wire logic [231:0] s_tdata,
    // action
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // node, sens_x, sens_y, sens_z
    output logic [103:0]      m_tdata,
    output logic              m_tlast
);

    localparam int KW  = $clog2(MAX_DIM);
    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = NW + 1;
    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int GW  = 32 * MAX_DIM;
    localparam int NRW = 64 * MAX_DIM;
    localparam logic signed [31:0] TT = 32'(((2 ** (FRAC_BITS + 1)) + 1) / 3);
    localparam logic [KW-1:0] LAST_K = KW'(MAX_DIM - 1);

    pvs_pkg::pvs_state_t state_reg, state_next;
    pvs_pkg::pvs_term_t  t_reg;
    pvs_pkg::pvs_mac_ctl_t mac_ctl;

    logic [1:0]    dim_reg;
    logic [3:0]    ncnt_reg;
    logic [DW-1:0] nd_reg, nd_cfg;
    logic [CW-1:0] nn_reg, nn_cfg;
    logic [KW-1:0] r_reg, i_reg, j_reg, k_reg;
    logic [NW-1:0] c_reg;
    logic          m_valid_reg;

    logic signed [31:0] nu_reg, d_reg, p_reg, inner_reg;
    logic signed [31:0] g_reg [MAX_DIM][MAX_DIM];
    logic signed [31:0] s_reg [MAX_DIM][MAX_DIM];
    logic signed [31:0] n_reg [MAX_DIM];
    logic signed [31:0] dv_reg [MAX_DIM];
    logic signed [31:0] sens_reg [3];
    logic signed [31:0] out_sens_reg [3];
    logic [2:0]         out_node_reg;
    logic               out_last_reg;

    logic signed [31:0] gm [MAX_DIM][MAX_DIM];
    logic signed [31:0] s_calc [MAX_DIM][MAX_DIM];
    logic signed [63:0] tr_sum;
    logic signed [31:0] tr, dn;
    logic signed [31:0] op_a, op_b;
    logic signed [63:0] acc;

    logic [2:0]         in_index;
    logic signed [31:0] in_row [3];
    logic signed [31:0] in_deriv [3];
    logic signed [31:0] in_visc;
    logic               accepted, g_we, n_we, out_free, c_last, k_last;
    logic [GW-1:0]      g_wdata, g_rdata;
    logic [NRW-1:0]     n_wdata, n_rdata;
    int                 nn_i;

    assign in_index = s_tdata[2:0];
    assign in_visc  = s_tdata[226:195];
    always_comb begin
        for (int f = 0; f < 3; f++) begin
            in_row[f]   = s_tdata[3 + 32*f +: 32];
            in_deriv[f] = s_tdata[99 + 32*f +: 32];
        end
    end

    assign s_tready = (state_reg == pvs_pkg::ST_IDLE);
    assign accepted = s_tvalid && s_tready;
    assign g_we = accepted && (s_tuser == pvs_pkg::ACT_LOAD_GRAD) && (int'(in_index) < MAX_DIM);
    assign n_we = accepted && (s_tuser == pvs_pkg::ACT_LOAD_NODE)
                  && (int'(in_index) < MAX_NODES);

    always_comb begin
        for (int f = 0; f < MAX_DIM; f++) begin
            g_wdata[32*f +: 32]             = in_row[f];
            n_wdata[32*f +: 32]             = in_row[f];
            n_wdata[32*(MAX_DIM + f) +: 32] = in_deriv[f];
        end
    end

    pvs_ram #(.WIDTH(GW), .DEPTH(MAX_DIM)) u_grad_ram (
        .aclk  (aclk),
        .we    (g_we),
        .waddr (in_index[KW-1:0]),
        .wdata (g_wdata),
        .raddr (r_reg),
        .rdata (g_rdata)
    );

    pvs_ram #(.WIDTH(NRW), .DEPTH(MAX_NODES)) u_node_ram (
        .aclk  (aclk),
        .we    (n_we),
        .waddr (in_index[NW-1:0]),
        .wdata (n_wdata),
        .raddr (c_reg),
        .rdata (n_rdata)
    );

    pvs_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    // effective configuration
    always_comb begin
        nd_cfg = (dim_reg == 2'd2 || MAX_DIM == 2) ? DW'(2) : DW'(3);
        if (ncnt_reg == 4'd0) begin
            nn_i = 1;
        end else if (int'(ncnt_reg) > MAX_NODES) begin
            nn_i = MAX_NODES;
        end else begin
            nn_i = int'(ncnt_reg);
        end
        nn_cfg = CW'(nn_i);
    end

    // masked gradient, trace and symmetric part
    always_comb begin
        tr_sum = 64'sd0;
        for (int i = 0; i < MAX_DIM; i++) begin
            for (int j = 0; j < MAX_DIM; j++) begin
                gm[i][j] = (i < int'(nd_reg) && j < int'(nd_reg)) ? g_reg[i][j] : 32'sd0;
            end
        end
        for (int i = 0; i < MAX_DIM; i++) begin
            tr_sum = tr_sum + 64'(gm[i][i]);
        end
        tr = pvs_pkg::sat32(tr_sum);
        dn = pvs_pkg::sat32(acc);
        for (int i = 0; i < MAX_DIM; i++) begin
            for (int j = 0; j < MAX_DIM; j++) begin
                if (i < int'(nd_reg) && j < int'(nd_reg)) begin
                    s_calc[i][j] = pvs_pkg::sat32(64'(gm[i][j]) + 64'(gm[j][i])
                                   - ((i == j) ? 64'(dn) : 64'sd0));
                end else begin
                    s_calc[i][j] = 32'sd0;
                end
            end
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign c_last   = (CW'(c_reg) == nn_reg - CW'(1));
    assign k_last   = (DW'(k_reg) == nd_reg - DW'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pvs_pkg::ST_IDLE: begin
                if (accepted && s_tuser == pvs_pkg::ACT_COMPUTE) begin
                    state_next = pvs_pkg::ST_G_RD;
                end
            end
            pvs_pkg::ST_G_RD:   state_next = pvs_pkg::ST_G_CAP;
            pvs_pkg::ST_G_CAP: begin
                state_next = (r_reg == LAST_K) ? pvs_pkg::ST_D_MUL : pvs_pkg::ST_G_RD;
            end
            pvs_pkg::ST_D_MUL:  state_next = pvs_pkg::ST_D_ACC;
            pvs_pkg::ST_D_ACC:  state_next = pvs_pkg::ST_S_CALC;
            pvs_pkg::ST_S_CALC: state_next = pvs_pkg::ST_P_MUL;
            pvs_pkg::ST_P_MUL:  state_next = pvs_pkg::ST_P_ACC;
            pvs_pkg::ST_P_ACC: begin
                state_next = (i_reg == LAST_K && j_reg == LAST_K) ? pvs_pkg::ST_P_END
                                                                   : pvs_pkg::ST_P_MUL;
            end
            pvs_pkg::ST_P_END:  state_next = pvs_pkg::ST_N_RD;
            pvs_pkg::ST_N_RD:   state_next = pvs_pkg::ST_N_CAP;
            pvs_pkg::ST_N_CAP:  state_next = pvs_pkg::ST_K_MUL;
            pvs_pkg::ST_K_MUL:  state_next = pvs_pkg::ST_K_ACC;
            pvs_pkg::ST_K_ACC: begin
                state_next = (t_reg == pvs_pkg::TERM_ND) ? pvs_pkg::ST_O_MUL1
                                                          : pvs_pkg::ST_K_MUL;
            end
            pvs_pkg::ST_O_MUL1: state_next = pvs_pkg::ST_O_ACC1;
            pvs_pkg::ST_O_ACC1: state_next = pvs_pkg::ST_O_MUL2;
            pvs_pkg::ST_O_MUL2: state_next = pvs_pkg::ST_O_ACC2;
            pvs_pkg::ST_O_ACC2: state_next = pvs_pkg::ST_O_END;
            pvs_pkg::ST_O_END: begin
                state_next = k_last ? pvs_pkg::ST_EMIT : pvs_pkg::ST_K_MUL;
            end
            pvs_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = c_last ? pvs_pkg::ST_IDLE : pvs_pkg::ST_N_RD;
                end
            end
            default:            state_next = pvs_pkg::ST_IDLE;
        endcase
    end

    // mac control and operand select
    always_comb begin
        mac_ctl = '0;
        op_a = 32'sd0;
        op_b = 32'sd0;
        case (state_reg)
            pvs_pkg::ST_D_MUL: begin
                mac_ctl.load = 1'b1;
                op_a = TT;
                op_b = tr;
            end
            pvs_pkg::ST_D_ACC: begin
                mac_ctl.acc = 1'b1;
                mac_ctl.clr = 1'b1;
            end
            pvs_pkg::ST_P_MUL: begin
                mac_ctl.load = 1'b1;
                op_a = s_reg[i_reg][j_reg];
                op_b = gm[i_reg][j_reg];
            end
            pvs_pkg::ST_P_ACC: begin
                mac_ctl.acc = 1'b1;
                mac_ctl.clr = (i_reg == '0) && (j_reg == '0);
            end
            pvs_pkg::ST_K_MUL: begin
                mac_ctl.load = 1'b1;
                op_a = n_reg[j_reg];
                case (t_reg)
                    pvs_pkg::TERM_GKJ: op_b = gm[k_reg][j_reg];
                    pvs_pkg::TERM_GJK: op_b = gm[j_reg][k_reg];
                    pvs_pkg::TERM_SKJ: op_b = s_reg[k_reg][j_reg];
                    pvs_pkg::TERM_ND: begin
                        op_a = n_reg[k_reg];
                        op_b = d_reg;
                    end
                    default:           op_b = 32'sd0;
                endcase
            end
            pvs_pkg::ST_K_ACC: begin
                mac_ctl.acc = 1'b1;
                mac_ctl.clr = (t_reg == pvs_pkg::TERM_GKJ) && (j_reg == '0);
                mac_ctl.neg = (t_reg == pvs_pkg::TERM_ND);
            end
            pvs_pkg::ST_O_MUL1: begin
                mac_ctl.load = 1'b1;
                op_a = dv_reg[k_reg];
                op_b = p_reg;
            end
            pvs_pkg::ST_O_ACC1: begin
                mac_ctl.acc = 1'b1;
                mac_ctl.clr = 1'b1;
            end
            pvs_pkg::ST_O_MUL2: begin
                mac_ctl.load = 1'b1;
                op_a = nu_reg;
                op_b = inner_reg;
            end
            pvs_pkg::ST_O_ACC2: begin
                mac_ctl.acc = 1'b1;
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pvs_pkg::ST_IDLE;
            dim_reg     <= 2'd3;
            ncnt_reg    <= 4'd4;
            m_valid_reg <= 1'b0;
            r_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            c_reg       <= '0;
            t_reg       <= pvs_pkg::TERM_GKJ;
            nd_reg      <= DW'(2);
            nn_reg      <= CW'(1);
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (cfg_addr == pvs_pkg::REG_DIMENSION) begin
                    dim_reg <= cfg_wdata[1:0];
                end else begin
                    ncnt_reg <= cfg_wdata;
                end
            end
            if (state_reg == pvs_pkg::ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                pvs_pkg::ST_IDLE: begin
                    r_reg  <= '0;
                    i_reg  <= '0;
                    j_reg  <= '0;
                    c_reg  <= '0;
                    nd_reg <= nd_cfg;
                    nn_reg <= nn_cfg;
                end
                pvs_pkg::ST_G_CAP: begin
                    if (r_reg != LAST_K) begin
                        r_reg <= r_reg + KW'(1);
                    end
                end
                pvs_pkg::ST_P_ACC: begin
                    if (j_reg == LAST_K) begin
                        j_reg <= '0;
                        if (i_reg != LAST_K) begin
                            i_reg <= i_reg + KW'(1);
                        end
                    end else begin
                        j_reg <= j_reg + KW'(1);
                    end
                end
                pvs_pkg::ST_N_CAP: begin
                    k_reg <= '0;
                    j_reg <= '0;
                    t_reg <= pvs_pkg::TERM_GKJ;
                end
                pvs_pkg::ST_K_ACC: begin
                    case (t_reg)
                        pvs_pkg::TERM_GKJ: t_reg <= pvs_pkg::TERM_GJK;
                        pvs_pkg::TERM_GJK: t_reg <= pvs_pkg::TERM_SKJ;
                        pvs_pkg::TERM_SKJ: begin
                            if (j_reg == LAST_K) begin
                                t_reg <= pvs_pkg::TERM_ND;
                            end else begin
                                t_reg <= pvs_pkg::TERM_GKJ;
                                j_reg <= j_reg + KW'(1);
                            end
                        end
                        default:           t_reg <= pvs_pkg::TERM_ND;
                    endcase
                end
                pvs_pkg::ST_O_END: begin
                    if (!k_last) begin
                        k_reg <= k_reg + KW'(1);
                    end
                    j_reg <= '0;
                    t_reg <= pvs_pkg::TERM_GKJ;
                end
                pvs_pkg::ST_EMIT: begin
                    if (out_free && !c_last) begin
                        c_reg <= c_reg + NW'(1);
                    end
                end
                default: begin
                    t_reg <= t_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accepted && s_tuser == pvs_pkg::ACT_COMPUTE) begin
            nu_reg <= in_visc;
        end
        if (state_reg == pvs_pkg::ST_G_CAP) begin
            for (int f = 0; f < MAX_DIM; f++) begin
                g_reg[r_reg][f] <= g_rdata[32*f +: 32];
            end
        end
        if (state_reg == pvs_pkg::ST_S_CALC) begin
            d_reg <= dn;
            s_reg <= s_calc;
        end
        if (state_reg == pvs_pkg::ST_P_END) begin
            p_reg <= dn;
        end
        if (state_reg == pvs_pkg::ST_N_CAP) begin
            for (int f = 0; f < MAX_DIM; f++) begin
                n_reg[f]  <= n_rdata[32*f +: 32];
                dv_reg[f] <= n_rdata[32*(MAX_DIM + f) +: 32];
            end
            for (int f = 0; f < 3; f++) begin
                sens_reg[f] <= 32'sd0;
            end
        end
        if (state_reg == pvs_pkg::ST_O_MUL1) begin
            inner_reg <= dn;
        end
        if (state_reg == pvs_pkg::ST_O_END) begin
            sens_reg[k_reg] <= dn;
        end
        if (state_reg == pvs_pkg::ST_EMIT && out_free) begin
            out_node_reg <= 3'(c_reg);
            out_sens_reg <= sens_reg;
            out_last_reg <= c_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_sens_reg[2], out_sens_reg[1], out_sens_reg[0], out_node_reg};

endmodule

`default_nettype wire

// ----- src/pvs_checker.sv -----
// port-level assertions for production_velocity_sensitivity, bound to the top level
// depends on production_velocity_sensitivity and pvs_pkg
`timescale 1ns / 1ps
`default_nettype none

module pvs_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         cfg_wr_en,
    input wire logic         cfg_addr,
    input wire logic [3:0]   cfg_wdata,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [231:0] s_tdata,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata,
    input wire logic         m_tlast
);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    // a compute beat makes the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == pvs_pkg::ACT_COMPUTE |=> !s_tready)
        else $error("input accepted during compute");

    // more nodes pending while a non-final result beat waits
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("idle before final node");

endmodule

bind production_velocity_sensitivity pvs_checker u_pvs_checker (.*);

`default_nettype wire
